@@ sv/wildcard_byte_signature_scan_core_defines.svh @@
// ============================================================================
// Assertion macros for the wildcard byte signature scan core
// Clocked concurrent checks, reset-qualified; compiled out with ASSERT_OFF.
// ============================================================================
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_CORE_DEFINES_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define WBSS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define WBSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WBSS_ASSERT_SAME(lbl, ante, cons, msg)

`define WBSS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/wbss_pkg.sv @@
// ============================================================================
// wbss_pkg
// Shared types and constants for the wildcard byte signature scan core.
// ============================================================================
package wbss_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int PAT_REGS   = 32;
    localparam int PAT_IDX_W  = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int PLEN_W     = 6;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE    = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic        found;
        logic [63:0] match_address;
    } out_beat_t;

    typedef struct packed {
        logic [PAT_REGS-1:0][7:0] pat_bytes;
        logic [PAT_REGS-1:0]      care;
    } pat_cfg_t;

endpackage

@@ sv/wbss_cfg.sv @@
// ============================================================================
// wbss_cfg
// Configuration registers: pattern bytes, care mask, clamped length, base.
// ============================================================================
module wbss_cfg #(
    parameter int PATTERN_MAX = wbss_pkg::PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [wbss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wbss_pkg::CFG_DATA_W-1:0]     cfg_data,
    output wbss_pkg::pat_cfg_t                  pat_cfg,
    output logic [LEN_W-1:0]                    len_eff,
    output logic [63:0]                         region_base
);

    logic [3:0][63:0]                 pattern_reg;
    logic [wbss_pkg::PAT_REGS-1:0]    care_reg;
    logic [wbss_pkg::PLEN_W-1:0]      plen_reg;
    logic [63:0]                      base_reg;
    logic [31:0]                      plen_ext;
    logic [31:0]                      plen_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            care_reg    <= '1;
            plen_reg    <= wbss_pkg::PLEN_W'(1);
            base_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wbss_pkg::REG_PATTERN_0:      pattern_reg[0] <= cfg_data;
                wbss_pkg::REG_PATTERN_1:      pattern_reg[1] <= cfg_data;
                wbss_pkg::REG_PATTERN_2:      pattern_reg[2] <= cfg_data;
                wbss_pkg::REG_PATTERN_3:      pattern_reg[3] <= cfg_data;
                wbss_pkg::REG_CARE_MASK:      care_reg <= cfg_data[wbss_pkg::PAT_REGS-1:0];
                wbss_pkg::REG_PATTERN_LENGTH: plen_reg <= cfg_data[wbss_pkg::PLEN_W-1:0];
                wbss_pkg::REG_REGION_BASE:    base_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        plen_ext = 32'(plen_reg);
        priority if (plen_ext == 32'd0)
            plen_clamped = 32'd1;
        else if (plen_ext > 32'(PATTERN_MAX))
            plen_clamped = 32'(PATTERN_MAX);
        else
            plen_clamped = plen_ext;
    end

    assign len_eff           = LEN_W'(plen_clamped);
    assign pat_cfg.pat_bytes = pattern_reg;
    assign pat_cfg.care      = care_reg;
    assign region_base       = base_reg;

endmodule

@@ sv/wbss_cell.sv @@
// ============================================================================
// wbss_cell
// One window cell: holds a byte, passes it on, compares it to its position.
// ============================================================================
module wbss_cell #(
    parameter int PATTERN_MAX = wbss_pkg::PATTERN_MAX_DEF,
    parameter int POS         = 0,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                clk,
    input  logic                shift_en,
    input  logic [7:0]          byte_in,
    input  logic [LEN_W-1:0]    len_eff,
    input  wbss_pkg::pat_cfg_t  pat_cfg,
    output logic [7:0]          byte_out,
    output logic                hit
);

    localparam logic [LEN_W-1:0] CELL_POS = LEN_W'(POS);

    logic [7:0]                       win_reg;
    logic                             in_use;
    logic [LEN_W-1:0]                 pos;
    logic                             has_reg;
    logic [wbss_pkg::PAT_IDX_W-1:0]   sel;

    always_ff @(posedge clk)
    begin
        if (shift_en)
            win_reg <= byte_in;
    end

    always_comb
    begin
        in_use  = CELL_POS < len_eff;
        pos     = len_eff - CELL_POS - LEN_W'(1);
        has_reg = 32'(pos) < 32'(wbss_pkg::PAT_REGS);
        sel     = wbss_pkg::PAT_IDX_W'(pos);
        hit     = !in_use || !has_reg || !pat_cfg.care[sel]
                  || (pat_cfg.pat_bytes[sel] == win_reg);
    end

    assign byte_out = win_reg;

endmodule

@@ sv/wildcard_byte_signature_scan_core.sv @@
// ============================================================================
// wildcard_byte_signature_scan_core
// Streams bytes through compare cells; reports a region's first match or a miss.
// ============================================================================
// An accepted beat passes the window/stage-1, stage-2 and output registers.
// Throughput: one byte per cycle unless out_ready stalls it; the window cells
// shift one byte per accepted beat and compare all positions in parallel.
// Reset: window count, match flag and pipeline valids clear; registers take
// pattern 0, care mask all ones, length 1, base 0.
`include "wildcard_byte_signature_scan_core_defines.svh"

module wildcard_byte_signature_scan_core #(
    parameter int PATTERN_MAX = wbss_pkg::PATTERN_MAX_DEF,
    parameter int COUNT_BITS  = wbss_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [wbss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbss_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  wbss_pkg::in_beat_t              in_beat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output wbss_pkg::out_beat_t             out_beat
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    wbss_pkg::pat_cfg_t       pat_cfg;
    logic [LEN_W-1:0]         len_eff;
    logic [63:0]              region_base;

    logic [7:0]               win_bytes [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]   hits;
    logic                     shift_en;

    logic [COUNT_BITS-1:0]    count_reg, count_next, count_inc;
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_last_reg;
    logic [COUNT_BITS-1:0]    s1_count_reg;
    logic                     match_seen_reg, match_seen_next;
    logic                     s2_valid_reg, s2_valid_next;
    logic                     s2_found_reg;
    logic [COUNT_BITS-1:0]    s2_offset_reg;
    logic                     out_valid_reg, out_valid_next;
    wbss_pkg::out_beat_t      out_beat_reg;

    logic                     s1_adv, s2_adv, s1_fire;
    logic                     s1_hit, s1_res;
    logic [COUNT_BITS-1:0]    len_cnt, s1_offset;

    wbss_cfg #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pat_cfg     (pat_cfg),
        .len_eff     (len_eff),
        .region_base (region_base)
    );

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic [7:0] cell_in;
        if (k == 0)
        begin : g_head
            assign cell_in = in_beat.data_byte;
        end
        else
        begin : g_body
            assign cell_in = win_bytes[k-1];
        end

        wbss_cell #(
            .PATTERN_MAX (PATTERN_MAX),
            .POS         (k),
            .LEN_W       (LEN_W)
        ) u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .byte_in  (cell_in),
            .len_eff  (len_eff),
            .pat_cfg  (pat_cfg),
            .byte_out (win_bytes[k]),
            .hit      (hits[k])
        );
    end

    // flow control
    assign s2_adv   = !out_valid_reg || out_ready;
    assign s1_adv   = !s2_valid_reg || s2_adv;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign shift_en = in_valid && in_ready;
    assign s1_fire  = s1_valid_reg && s1_adv;

    // byte count, saturating
    always_comb
    begin
        count_inc  = (count_reg == '1) ? count_reg : count_reg + COUNT_BITS'(1);
        count_next = count_reg;
        if (shift_en)
            count_next = in_beat.last_byte ? '0 : count_inc;
    end

    // window decision
    always_comb
    begin
        len_cnt   = COUNT_BITS'(len_eff);
        s1_hit    = !match_seen_reg && (&hits) && (s1_count_reg >= len_cnt);
        s1_res    = s1_hit || (s1_last_reg && !match_seen_reg);
        s1_offset = s1_count_reg - len_cnt;

        match_seen_next = match_seen_reg;
        if (s1_fire)
            match_seen_next = s1_last_reg ? 1'b0 : (match_seen_reg || s1_hit);

        s1_valid_next = s1_valid_reg;
        if (shift_en)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (s1_fire)
            s2_valid_next = s1_res;
        else if (s2_adv)
            s2_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s2_adv)
            out_valid_next = s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            match_seen_reg <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            s1_valid_reg   <= s1_valid_next;
            match_seen_reg <= match_seen_next;
            s2_valid_reg   <= s2_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            s1_last_reg  <= in_beat.last_byte;
            s1_count_reg <= count_inc;
        end
        if (s1_fire)
        begin
            s2_found_reg  <= s1_hit;
            s2_offset_reg <= s1_offset;
        end
        if (s2_adv && s2_valid_reg)
        begin
            out_beat_reg.found         <= s2_found_reg;
            out_beat_reg.match_address <= s2_found_reg
                                          ? region_base + 64'(s2_offset_reg) : 64'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    `WBSS_ASSERT_SAME(a_notfound_zero, out_valid && !out_beat.found, out_beat.match_address == 64'd0, "not-found beat with nonzero address")
    `WBSS_ASSERT_NEXT(a_match_latched, s1_fire && s1_hit && !s1_last_reg, match_seen_reg, "match flag not set after hit")
    `WBSS_ASSERT_NEXT(a_last_clears, shift_en && in_beat.last_byte, count_reg == '0, "byte count not cleared after last beat")
    `WBSS_ASSERT_SAME(a_single_report, s1_fire && match_seen_reg, !s1_hit, "second match reported in one region")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the wildcard byte signature scan core. A shadow
// scanner tracks the byte window, region count and match flag, and predicts
// the found / not-found report of each region. Directed regions hit the
// reset setting, length clamping, wildcards, a match on the final byte and a
// register change inside an open region, and one long output stall that
// backs up the input. Random regions then embed the pattern, near misses
// and noise under many settings; random idling on both sides, bar one phase.
// ============================================================================
module testbench;

    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 100;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_write;
    logic [wbss_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [wbss_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    wbss_pkg::in_beat_t              in_beat;
    logic                            out_valid;
    logic                            out_ready;
    wbss_pkg::out_beat_t             out_beat;

    wildcard_byte_signature_scan_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow scanner
    logic [63:0] shadow_pattern [4];
    logic [31:0] shadow_care;
    logic [5:0]  shadow_length;
    logic [63:0] shadow_base;
    logic [7:0]  scan_window [wbss_pkg::PATTERN_MAX_DEF];
    logic [31:0] scan_count;
    bit          scan_matched;

    wbss_pkg::out_beat_t pending_reports [$];

    int send_idle_pct = 25;
    int recv_idle_pct = 25;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_len      = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int mismatches    = 0;
    int bytes_sent    = 0;
    int reports_seen  = 0;
    int stall_cycles  = 0;
    int settings_used = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH %s: got %h, want %h (report %0d, cycle %0d)",
                     what, got, want, reports_seen, cycle_count);
        mismatches++;
    endtask

    function automatic void clear_region();
        foreach (scan_window[i])
            scan_window[i] = 8'h00;
        scan_count   = '0;
        scan_matched = 1'b0;
    endfunction

    function automatic void reset_shadow();
        foreach (shadow_pattern[i])
            shadow_pattern[i] = '0;
        shadow_care   = '1;
        shadow_length = 6'd1;
        shadow_base   = '0;
        clear_region();
    endfunction

    function automatic bit window_hit(input int len);
        logic [7:0] want;
        for (int p = 0; p < len; p++)
        begin
            if (p < wbss_pkg::PAT_REGS && shadow_care[p])
            begin
                want = shadow_pattern[p / 8][(p % 8) * 8 +: 8];
                if (want != scan_window[len - 1 - p])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit scan_next_byte(input wbss_pkg::in_beat_t beat,
                                          output wbss_pkg::out_beat_t rpt);
        int len;
        bit has_report;
        len = int'(shadow_length);
        if (len < 1)
            len = 1;
        if (len > wbss_pkg::PATTERN_MAX_DEF)
            len = wbss_pkg::PATTERN_MAX_DEF;
        for (int i = wbss_pkg::PATTERN_MAX_DEF - 1; i > 0; i--)
            scan_window[i] = scan_window[i - 1];
        scan_window[0] = beat.data_byte;
        if (scan_count != '1)
            scan_count++;
        has_report = 1'b0;
        rpt = '0;
        if (!scan_matched && 64'(scan_count) >= 64'(len) && window_hit(len))
        begin
            scan_matched = 1'b1;
            rpt.found = 1'b1;
            rpt.match_address = shadow_base + (64'(scan_count) - 64'(len));
            has_report = 1'b1;
        end
        else if (beat.last_byte && !scan_matched)
            has_report = 1'b1;
        if (beat.last_byte)
            clear_region();
        return has_report;
    endfunction

    task automatic write_reg(input logic [wbss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            wbss_pkg::REG_PATTERN_0, wbss_pkg::REG_PATTERN_1,
            wbss_pkg::REG_PATTERN_2, wbss_pkg::REG_PATTERN_3:
                shadow_pattern[idx - wbss_pkg::REG_PATTERN_0] = value;
            wbss_pkg::REG_CARE_MASK:      shadow_care   = value[31:0];
            wbss_pkg::REG_PATTERN_LENGTH: shadow_length = value[wbss_pkg::PLEN_W-1:0];
            wbss_pkg::REG_REGION_BASE:    shadow_base   = value;
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] data, input logic last);
        wbss_pkg::in_beat_t  beat;
        wbss_pkg::out_beat_t rpt;
        beat.data_byte = data;
        beat.last_byte = last;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (!in_ready)
        begin
            stall_cycles++;
            @(posedge clk);
        end
        bytes_sent++;
        if (scan_next_byte(beat, rpt))
            pending_reports.push_back(rpt);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_idle();
    endtask

    task automatic test_length_clamp();
        write_reg(wbss_pkg::REG_PATTERN_0, 64'h0000_0000_0000_00FF);
        write_reg(wbss_pkg::REG_PATTERN_LENGTH, 64'd0);
        write_reg(wbss_pkg::REG_REGION_BASE, '1);
        send_byte(8'h12, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_idle();
    endtask

    task automatic test_wildcards();
        write_reg(wbss_pkg::REG_PATTERN_0, 64'h0000_0000_0033_2211);
        write_reg(wbss_pkg::REG_CARE_MASK, 64'h5);
        write_reg(wbss_pkg::REG_PATTERN_LENGTH, 64'd3);
        write_reg(wbss_pkg::REG_REGION_BASE, 64'h100);
        send_byte(8'h11, 1'b0);
        send_byte(8'h99, 1'b0);
        send_byte(8'h33, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h34, 1'b1);
        wait_idle();
    endtask

    task automatic test_mid_region_write();
        write_reg(wbss_pkg::REG_PATTERN_0, 64'h0000_0000_0000_5AA5);
        write_reg(wbss_pkg::REG_CARE_MASK, 64'hFFFF_FFFF);
        write_reg(wbss_pkg::REG_PATTERN_LENGTH, 64'd2);
        write_reg(wbss_pkg::REG_REGION_BASE, 64'h1000);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        wait_idle();
        write_reg(wbss_pkg::REG_PATTERN_LENGTH, 64'd1);
        write_reg(wbss_pkg::REG_PATTERN_0, 64'h0000_0000_0000_005A);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_idle();
    endtask

    task automatic run_random_phase(input int n_items, input int setting_kind);
        logic [63:0] pat_words [4];
        logic [31:0] care;
        logic [5:0]  len_code;
        logic [63:0] base;
        logic [7:0]  data;
        int eff, sent, rlen, start, k, p, mode, flip_pos, pick, wsel, bsel;
        for (k = 0; k < 4; k++)
            pat_words[k] = {$urandom, $urandom};
        case (setting_kind)
            1:
            begin
                foreach (pat_words[i])
                    pat_words[i] = '1;
                care     = '1;
                len_code = 6'd63;
                base     = '1;
            end
            2:
            begin
                foreach (pat_words[i])
                    pat_words[i] = '0;
                care     = '0;
                len_code = 6'd32;
                base     = '0;
            end
            default:
            begin
                pick = $urandom_range(9);
                if (pick <= 5)
                    len_code = 6'($urandom_range(1, 6));
                else if (pick == 6)
                    len_code = 6'd0;
                else if (pick == 7)
                    len_code = 6'd32;
                else if (pick == 8)
                    len_code = 6'($urandom_range(33, 63));
                else
                    len_code = 6'($urandom_range(7, 31));
                case ($urandom_range(3))
                    0: care = '1;
                    1: care = $urandom;
                    2: care = $urandom & $urandom;
                    default: care = ~(32'h1 << $urandom_range(31));
                endcase
                case ($urandom_range(4))
                    0: base = '0;
                    1: base = '1;
                    2: base = {56'hFF_FFFF_FFFF_FFFF, 8'($urandom)};
                    default: base = {$urandom, $urandom};
                endcase
            end
        endcase
        for (k = 0; k < 4; k++)
            write_reg(wbss_pkg::REG_PATTERN_0 + k[wbss_pkg::CFG_IDX_W-1:0], pat_words[k]);
        write_reg(wbss_pkg::REG_CARE_MASK, 64'(care));
        write_reg(wbss_pkg::REG_PATTERN_LENGTH, 64'(len_code));
        write_reg(wbss_pkg::REG_REGION_BASE, base);
        settings_used++;
        eff = (len_code == 0) ? 1
            : (len_code > wbss_pkg::PATTERN_MAX_DEF) ? wbss_pkg::PATTERN_MAX_DEF
                                                      : int'(len_code);
        sent = 0;
        while (sent < n_items)
        begin
            mode     = $urandom_range(9);
            start    = $urandom_range(0, 5);
            flip_pos = $urandom_range(0, eff - 1);
            if (mode < 7)
                rlen = start + eff + $urandom_range(0, 4);
            else if (mode == 7)
                rlen = start + $urandom_range(1, eff);
            else
                rlen = $urandom_range(1, eff + 6);
            for (k = 0; k < rlen; k++)
            begin
                p    = k - start;
                data = 8'($urandom);
                wsel = $urandom_range(0, 3);
                bsel = $urandom_range(0, 7);
                if (mode < 8 && p >= 0 && p < eff && care[p])
                begin
                    data = pat_words[p / 8][(p % 8) * 8 +: 8];
                    if (mode >= 5 && p == flip_pos)
                        data = data ^ 8'($urandom_range(1, 255));
                end
                else if (mode >= 8 && $urandom_range(1) == 1)
                    data = pat_words[wsel][bsel * 8 +: 8];
                send_byte(data, k == rlen - 1);
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        write_reg(wbss_pkg::REG_CARE_MASK, 64'h0);
        write_reg(wbss_pkg::REG_PATTERN_LENGTH, 64'd1);
        write_reg(wbss_pkg::REG_REGION_BASE, {$urandom, $urandom});
        send_idle_pct = 0;
        hold_len <= 400;
        hold_req <= hold_req + 1;
        for (int i = 0; i < 80; i++)
            send_byte(8'($urandom), 1'b1);
        send_idle_pct = 25;
        wait_idle();
    endtask

    task automatic test_full_rate();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_random_phase(120, 0);
        wait_idle();
        send_idle_pct = 25;
        recv_idle_pct <= 25;
    endtask

    task automatic test_random_regions();
        run_random_phase(75, 1);
        wait_idle();
        run_random_phase(75, 2);
        wait_idle();
        for (int i = 0; i < 7; i++)
        begin
            run_random_phase(75, 0);
            wait_idle();
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= hold_len;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_reports
        wbss_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
                report_mismatch("report with none pending", out_beat.match_address, '0);
            else
            begin
                want = pending_reports.pop_front();
                if (out_beat.found !== want.found)
                    report_mismatch("found", 64'(out_beat.found), 64'(want.found));
                if (out_beat.match_address !== want.match_address)
                    report_mismatch("match_address", out_beat.match_address,
                                    want.match_address);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_beat   <= '0;
        out_ready <= 1'b0;
        reset_shadow();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_length_clamp();
        test_wildcards();
        test_mid_region_write();
        test_backpressure();
        test_full_rate();
        test_random_regions();

        wait_idle();
        if (pending_reports.size() != 0)
            report_mismatch("reports never delivered", 64'(pending_reports.size()), '0);
        $display("Scanned %0d bytes under %0d random pattern settings plus directed cases",
                 bytes_sent, settings_used);
        $display("Compared %0d reports; input stalled %0d cycles; %0d mismatches",
                 reports_seen, stall_cycles, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
